### src/linear_probe_key_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe key table
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_KEY_TABLE_MACROS_SVH
`define LINEAR_PROBE_KEY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define LPKT_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define LPKT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LPKT_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define LPKT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### src/lpkt_pkg.sv
// ----------------------------------------------------------------------------
// lpkt_pkg
// Shared types and constants of the linear probe key table.
// ----------------------------------------------------------------------------
package lpkt_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned TYPE_W   = 5;
  localparam int unsigned SCORE_W  = 5;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned HANDLE_W = 20;
  localparam int unsigned RANK_W   = 5;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAND_W   = HANDLE_W + SCORE_W + LEN_W;

  localparam logic [OP_W-1:0] OP_MARK = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_P_RD,
    S_P_CK,
    S_A_CHK,
    S_A_RD,
    S_A_CMP,
    S_A_PUT,
    S_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load;
    logic    clr_wr;
    logic    probe_next;
    logic    take_entry;
    logic    cand_shift;
    logic    cand_put;
    logic    slot_wr;
    logic    stat_wr;
    status_e stat_val;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic            used;
    logic            match;
    logic            probe_last;
    logic            list_full;
    logic            pos_zero;
    logic            pos_one;
    logic            move;
    logic            out_free;
    logic [OP_W-1:0] op;
  } stat_t;

endpackage

### src/linear_probe_key_table.sv
// Sequence: an item walks the slots from its key's home slot; an add with room then compares
// the stored candidates to find its place. One transaction is in flight; the next is taken
// the cycle after the result register loads, and a stalled result holds input.
// Reset: async active low; then a clearing pass over all 2^TABLE_BITS slots empties the
// table, with in_ready_o low until it completes.
// ----------------------------------------------------------------------------
// linear_probe_key_table
// Open-addressed hash table with type marks and ranked candidate lists.
// ----------------------------------------------------------------------------
module linear_probe_key_table #(
  parameter int unsigned TABLE_BITS = 12,
  parameter int unsigned MAX_CAND   = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpkt_pkg::OP_W-1:0]     opcode_i,
  input  logic [lpkt_pkg::KEY_W-1:0]    key_i,
  input  logic [lpkt_pkg::MASK_W-1:0]   type_mask_i,
  input  logic [lpkt_pkg::SCORE_W-1:0]  cand_weight_i,
  input  logic [lpkt_pkg::LEN_W-1:0]    cand_length_i,
  input  logic [lpkt_pkg::HANDLE_W-1:0] cand_handle_i,
  input  logic [lpkt_pkg::RANK_W-1:0]   rank_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpkt_pkg::STAT_W-1:0]   status_o,
  output logic [lpkt_pkg::SLOT_W-1:0]   slot_o,
  output logic                          was_inserted_o,
  output logic                          type_known_o,
  output logic [lpkt_pkg::MASK_W-1:0]   type_bits_o,
  output logic [lpkt_pkg::COUNT_W-1:0]  cand_count_o,
  output logic                          cand_kept_o,
  output logic [lpkt_pkg::HANDLE_W-1:0] out_handle_o,
  output logic [lpkt_pkg::SCORE_W-1:0]  out_score_o,
  output logic [lpkt_pkg::LEN_W-1:0]    out_length_o
);
  import lpkt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lpkt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lpkt_dp #(
    .TABLE_BITS (TABLE_BITS),
    .MAX_CAND   (MAX_CAND)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (opcode_i),
    .key_i          (key_i),
    .type_mask_i    (type_mask_i),
    .cand_weight_i  (cand_weight_i),
    .cand_length_i  (cand_length_i),
    .cand_handle_i  (cand_handle_i),
    .rank_i         (rank_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .was_inserted_o (was_inserted_o),
    .type_known_o   (type_known_o),
    .type_bits_o    (type_bits_o),
    .cand_count_o   (cand_count_o),
    .cand_kept_o    (cand_kept_o),
    .out_handle_o   (out_handle_o),
    .out_score_o    (out_score_o),
    .out_length_o   (out_length_o)
  );

endmodule

### src/lpkt_ctrl.sv
// ----------------------------------------------------------------------------
// lpkt_ctrl
// Sequencer: clearing pass, probe walk, sorted insert and result handoff.
// ----------------------------------------------------------------------------
module lpkt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lpkt_pkg::stat_t stat_i,
  output lpkt_pkg::cmd_t  cmd_o
);
  import lpkt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.stat_val = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_P_RD;
        end
      end
      S_P_RD: state_d = S_P_CK;
      S_P_CK: begin
        if (!stat_i.used || stat_i.match) begin
          cmd_o.take_entry = 1'b1;
          if (stat_i.op == OP_MARK) begin
            state_d = S_WR;
          end else if (stat_i.op == OP_ADD) begin
            state_d = S_A_CHK;
          end else begin
            if (!stat_i.used) begin
              cmd_o.stat_wr  = 1'b1;
              cmd_o.stat_val = ST_NOT_FOUND;
            end
            state_d = S_DONE;
          end
        end else if (stat_i.probe_last) begin
          cmd_o.stat_wr  = 1'b1;
          cmd_o.stat_val = ST_FULL;
          state_d        = S_DONE;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_P_RD;
        end
      end
      S_A_CHK: begin
        if (stat_i.list_full) state_d = S_WR;
        else if (stat_i.pos_zero) state_d = S_A_PUT;
        else state_d = S_A_RD;
      end
      S_A_RD: state_d = S_A_CMP;
      S_A_CMP: begin
        if (stat_i.move) begin
          cmd_o.cand_shift = 1'b1;
          state_d = stat_i.pos_one ? S_A_PUT : S_A_RD;
        end else begin
          state_d = S_A_PUT;
        end
      end
      S_A_PUT: begin
        cmd_o.cand_put = 1'b1;
        state_d        = S_WR;
      end
      S_WR: begin
        cmd_o.slot_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### src/lpkt_dp.sv
// ----------------------------------------------------------------------------
// lpkt_dp
// Slot and candidate memories, probe registers and the result register.
// ----------------------------------------------------------------------------
`include "linear_probe_key_table_macros.svh"

module lpkt_dp #(
  parameter int unsigned TABLE_BITS = 12,
  parameter int unsigned MAX_CAND   = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lpkt_pkg::cmd_t                   cmd_i,
  output lpkt_pkg::stat_t                  stat_o,
  input  logic [lpkt_pkg::OP_W-1:0]        opcode_i,
  input  logic [lpkt_pkg::KEY_W-1:0]       key_i,
  input  logic [lpkt_pkg::MASK_W-1:0]      type_mask_i,
  input  logic [lpkt_pkg::SCORE_W-1:0]     cand_weight_i,
  input  logic [lpkt_pkg::LEN_W-1:0]       cand_length_i,
  input  logic [lpkt_pkg::HANDLE_W-1:0]    cand_handle_i,
  input  logic [lpkt_pkg::RANK_W-1:0]      rank_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lpkt_pkg::STAT_W-1:0]      status_o,
  output logic [lpkt_pkg::SLOT_W-1:0]      slot_o,
  output logic                             was_inserted_o,
  output logic                             type_known_o,
  output logic [lpkt_pkg::MASK_W-1:0]      type_bits_o,
  output logic [lpkt_pkg::COUNT_W-1:0]     cand_count_o,
  output logic                             cand_kept_o,
  output logic [lpkt_pkg::HANDLE_W-1:0]    out_handle_o,
  output logic [lpkt_pkg::SCORE_W-1:0]     out_score_o,
  output logic [lpkt_pkg::LEN_W-1:0]       out_length_o
);
  import lpkt_pkg::*;

  localparam int unsigned TS = 1 << TABLE_BITS;
  localparam int unsigned CW = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
  localparam int unsigned NW = $clog2(MAX_CAND + 1);
  localparam int unsigned CS = 1 << (TABLE_BITS + CW);

  // slot and candidate stores
  logic                used_mem [TS];
  logic [KEY_W-1:0]    key_mem  [TS];
  logic [TYPE_W-1:0]   type_mem [TS];
  logic [NW-1:0]       cnt_mem  [TS];
  logic [CAND_W-1:0]   cand_mem [CS];

  logic [OP_W-1:0]       op_q;
  logic [KEY_W-1:0]      key_q;
  logic [MASK_W-1:0]     mask_q;
  logic [SCORE_W-1:0]    score_q;
  logic [LEN_W-1:0]      len_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic [RANK_W-1:0]     rank_q;
  logic [TABLE_BITS-1:0] idx_q, n_q, clr_q;
  logic [CW-1:0]         pos_q;
  logic                  ins_q, kept_q;
  logic [TYPE_W-1:0]     type_q;
  logic [NW-1:0]         cnt_q;
  status_e               res_stat_q;

  logic                  used_rd;
  logic [KEY_W-1:0]      key_rd;
  logic [TYPE_W-1:0]     type_rd;
  logic [NW-1:0]         cnt_rd;
  logic [CAND_W-1:0]     cand_rd;

  logic                  out_valid_q;
  logic [STAT_W-1:0]     status_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  ins_out_q, known_q, kept_out_q;
  logic [MASK_W-1:0]     bits_q;
  logic [COUNT_W-1:0]    count_q;
  logic [CAND_W-1:0]     cand_out_q;

  logic                  is_mark, is_add, is_read, rank_ok, ok;
  logic [TABLE_BITS-1:0] slot_addr;
  logic [CW-1:0]         cpos;
  logic [TABLE_BITS+CW-1:0] cand_raddr, cand_waddr;
  logic [CAND_W-1:0]     cand_wdata;
  logic [SCORE_W-1:0]    ps;
  logic [LEN_W-1:0]      pl;
  logic [TYPE_W-1:0]     type_take;
  logic [NW-1:0]         cnt_take;
  logic [TABLE_BITS+SLOT_W-1:0] slot_ext;
  logic [NW+COUNT_W-1:0] cnt_ext;

  assign is_mark = (op_q == OP_MARK);
  assign is_add  = (op_q == OP_ADD);
  assign is_read = !is_mark && !is_add;

  assign slot_addr  = cmd_i.clr_wr ? clr_q : idx_q;
  assign cpos       = is_read ? rank_q[CW-1:0] : pos_q - 1'b1;
  assign cand_raddr = {idx_q, cpos};
  assign cand_waddr = {idx_q, pos_q};
  assign cand_wdata = cmd_i.cand_put ? {handle_q, score_q, len_q} : cand_rd;

  assign ps = cand_rd[LEN_W +: SCORE_W];
  assign pl = cand_rd[LEN_W-1:0];

  assign rank_ok = (32'(rank_q) < 32'(cnt_q)) && (32'(rank_q) < MAX_CAND);

  always_comb begin
    cnt_take = used_rd ? cnt_rd : '0;
    if (is_mark) begin
      if (used_rd && type_rd[TYPE_W-1]) type_take = type_rd | {1'b0, mask_q};
      else type_take = {1'b1, mask_q};
    end else begin
      type_take = used_rd ? type_rd : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.slot_wr) begin
      used_mem[slot_addr] <= !cmd_i.clr_wr;
      key_mem[slot_addr]  <= key_q;
      type_mem[slot_addr] <= type_q;
      cnt_mem[slot_addr]  <= cnt_q;
    end
    used_rd <= used_mem[slot_addr];
    key_rd  <= key_mem[slot_addr];
    type_rd <= type_mem[slot_addr];
    cnt_rd  <= cnt_mem[slot_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_shift || cmd_i.cand_put) cand_mem[cand_waddr] <= cand_wdata;
    cand_rd <= cand_mem[cand_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      res_stat_q  <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) res_stat_q <= ST_OK;
      else if (cmd_i.stat_wr) res_stat_q <= cmd_i.stat_val;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      key_q    <= key_i;
      mask_q   <= type_mask_i;
      score_q  <= cand_weight_i;
      len_q    <= cand_length_i;
      handle_q <= cand_handle_i;
      rank_q   <= rank_i;
      idx_q    <= key_i[TABLE_BITS-1:0];
      n_q      <= '0;
      kept_q   <= 1'b0;
    end
    if (cmd_i.probe_next) begin
      idx_q <= idx_q + 1'b1;
      n_q   <= n_q + 1'b1;
    end
    if (cmd_i.take_entry) begin
      ins_q  <= !used_rd;
      type_q <= type_take;
      cnt_q  <= cnt_take;
      pos_q  <= cnt_take[CW-1:0];
    end
    if (cmd_i.cand_shift) pos_q <= pos_q - 1'b1;
    if (cmd_i.cand_put) begin
      cnt_q  <= cnt_q + 1'b1;
      kept_q <= 1'b1;
    end
  end

  assign ok       = (res_stat_q == ST_OK);
  assign slot_ext = {{SLOT_W{1'b0}}, idx_q};
  assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q   <= res_stat_q;
      slot_q     <= ok ? slot_ext[SLOT_W-1:0] : '0;
      ins_out_q  <= ok && ins_q;
      known_q    <= ok && type_q[TYPE_W-1];
      bits_q     <= ok ? type_q[MASK_W-1:0] : '0;
      count_q    <= ok ? cnt_ext[COUNT_W-1:0] : '0;
      kept_out_q <= ok && kept_q;
      cand_out_q <= (ok && is_read && rank_ok) ? cand_rd : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign was_inserted_o = ins_out_q;
  assign type_known_o   = known_q;
  assign type_bits_o    = bits_q;
  assign cand_count_o   = count_q;
  assign cand_kept_o    = kept_out_q;
  assign out_handle_o   = cand_out_q[CAND_W-1 -: HANDLE_W];
  assign out_score_o    = cand_out_q[LEN_W +: SCORE_W];
  assign out_length_o   = cand_out_q[LEN_W-1:0];

  assign stat_o.clr_last   = &clr_q;
  assign stat_o.used       = used_rd;
  assign stat_o.match      = (key_rd == key_q);
  assign stat_o.probe_last = &n_q;
  assign stat_o.list_full  = (32'(cnt_q) >= MAX_CAND);
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.pos_one    = (pos_q == CW'(1));
  assign stat_o.move       = (ps < score_q) || ((ps == score_q) && (pl > len_q));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.op         = op_q;

  `LPKT_ASSERT_IMPL(a_room, clk_i, rst_ni, cmd_i.cand_put, !stat_o.list_full, "list overflow")
  `LPKT_ASSERT_IMPL(a_shift_pos, clk_i, rst_ni, cmd_i.cand_shift, pos_q != '0, "shift at head")
  `LPKT_ASSERT_IMPL(a_nf, clk_i, rst_ni, res_stat_q == ST_NOT_FOUND, is_read, "bad not found")
  `LPKT_ASSERT_NEXT(a_out_set, clk_i, rst_ni, cmd_i.out_load, out_valid_q, "result not presented")

endmodule

### dv/lpkt_checker.sv
// ----------------------------------------------------------------------------
// lpkt_checker
// Watches both channels of the linear probe key table, keeps its own copy of
// the table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module lpkt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [lpkt_pkg::OP_W-1:0]     opcode_i,
  input  logic [lpkt_pkg::KEY_W-1:0]    key_i,
  input  logic [lpkt_pkg::MASK_W-1:0]   type_mask_i,
  input  logic [lpkt_pkg::SCORE_W-1:0]  cand_weight_i,
  input  logic [lpkt_pkg::LEN_W-1:0]    cand_length_i,
  input  logic [lpkt_pkg::HANDLE_W-1:0] cand_handle_i,
  input  logic [lpkt_pkg::RANK_W-1:0]   rank_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [lpkt_pkg::STAT_W-1:0]   status_i,
  input  logic [lpkt_pkg::SLOT_W-1:0]   slot_i,
  input  logic                          was_inserted_i,
  input  logic                          type_known_i,
  input  logic [lpkt_pkg::MASK_W-1:0]   type_bits_i,
  input  logic [lpkt_pkg::COUNT_W-1:0]  cand_count_i,
  input  logic                          cand_kept_i,
  input  logic [lpkt_pkg::HANDLE_W-1:0] out_handle_i,
  input  logic [lpkt_pkg::SCORE_W-1:0]  out_score_i,
  input  logic [lpkt_pkg::LEN_W-1:0]    out_length_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import lpkt_pkg::*;

  localparam int SLOTS = 4096;
  localparam int CANDS = 20;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SCORE_W-1:0]  score;
    logic [LEN_W-1:0]    length;
  } cand_t;

  typedef struct {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic                inserted;
    logic                known;
    logic [MASK_W-1:0]   bits;
    logic [COUNT_W-1:0]  count;
    logic                kept;
    logic [HANDLE_W-1:0] handle;
    logic [SCORE_W-1:0]  score;
    logic [LEN_W-1:0]    length;
  } entry_result_t;

  bit                 used_tab[SLOTS];
  logic [KEY_W-1:0]   key_tab[SLOTS];
  logic [MASK_W-1:0]  bits_tab[SLOTS];
  bit                 known_tab[SLOTS];
  int                 count_tab[SLOTS];
  cand_t              cand_tab[SLOTS][CANDS];

  entry_result_t expected_q[$];
  int fails = 0;
  int n_results = 0, n_full = 0, n_missing = 0, n_dropped = 0, n_inserted = 0;

  assign fail_count_o = fails;

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic table_step(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [MASK_W-1:0] mask, input cand_t cand,
                            input int rank, output entry_result_t r);
    int idx;
    int hit;
    int pos;
    idx = int'(key[11:0]);
    hit = 2;
    r = '{ST_OK, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0, '0, '0};
    for (int n = 0; n < SLOTS; n++) begin
      if (!used_tab[idx]) begin
        hit = 1;
        break;
      end
      if (key_tab[idx] == key) begin
        hit = 0;
        break;
      end
      idx = (idx + 1) % SLOTS;
    end
    if (hit == 2) begin
      r.status = ST_FULL;
      return;
    end
    if (op == OP_MARK || op == OP_ADD) begin
      if (hit == 1) begin
        used_tab[idx] = 1'b1;
        key_tab[idx] = key;
        known_tab[idx] = 1'b0;
        bits_tab[idx] = '0;
        count_tab[idx] = 0;
        r.inserted = 1'b1;
      end
      if (op == OP_MARK) begin
        bits_tab[idx] = known_tab[idx] ? (bits_tab[idx] | mask) : mask;
        known_tab[idx] = 1'b1;
      end else if (count_tab[idx] < CANDS) begin
        // sorted insert: higher score first, then shorter, ties keep arrival order
        pos = count_tab[idx];
        while (pos > 0 && (cand_tab[idx][pos-1].score < cand.score ||
               (cand_tab[idx][pos-1].score == cand.score &&
                cand_tab[idx][pos-1].length > cand.length))) begin
          cand_tab[idx][pos] = cand_tab[idx][pos-1];
          pos--;
        end
        cand_tab[idx][pos] = cand;
        count_tab[idx]++;
        r.kept = 1'b1;
      end
    end else begin
      if (hit == 1) begin
        r.status = ST_NOT_FOUND;
        return;
      end
      if (rank < count_tab[idx]) begin
        r.handle = cand_tab[idx][rank].handle;
        r.score  = cand_tab[idx][rank].score;
        r.length = cand_tab[idx][rank].length;
      end
    end
    r.slot = SLOT_W'(idx);
    r.known = known_tab[idx];
    r.bits = bits_tab[idx];
    r.count = COUNT_W'(count_tab[idx]);
  endtask

  always @(posedge clk_i) begin
    entry_result_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report("unexpected transaction", status_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (status_i != want.status) report("status", status_i, want.status);
          if (slot_i != want.slot) report("slot", slot_i, want.slot);
          if (was_inserted_i != want.inserted)
            report("was_inserted", was_inserted_i, want.inserted);
          if (type_known_i != want.known) report("type_known", type_known_i, want.known);
          if (type_bits_i != want.bits) report("type_bits", type_bits_i, want.bits);
          if (cand_count_i != want.count) report("cand_count", cand_count_i, want.count);
          if (cand_kept_i != want.kept) report("cand_kept", cand_kept_i, want.kept);
          if (out_handle_i != want.handle) report("out_handle", out_handle_i, want.handle);
          if (out_score_i != want.score) report("out_score", out_score_i, want.score);
          if (out_length_i != want.length) report("out_length", out_length_i, want.length);
        end
      end
      if (in_valid_i && in_ready_i) begin
        table_step(opcode_i, key_i, type_mask_i,
                   '{cand_handle_i, cand_weight_i, cand_length_i}, int'(rank_i), want);
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_NOT_FOUND) n_missing++;
        if (opcode_i == OP_ADD && want.status == ST_OK && !want.kept) n_dropped++;
        if (want.inserted) n_inserted++;
        expected_q.push_back(want);
      end
    end
    pending_o <= expected_q.size();
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the linear probe key table: directed corner items, then random
// traffic on a small key pool under several idle/stall mixes and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import lpkt_pkg::*;

  localparam logic [OP_W-1:0] OP_READ     = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_ALT = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [OP_W-1:0]     opcode = '0;
  logic [KEY_W-1:0]    key = '0;
  logic [MASK_W-1:0]   type_mask = '0;
  logic [SCORE_W-1:0]  cand_weight = '0;
  logic [LEN_W-1:0]    cand_length = '0;
  logic [HANDLE_W-1:0] cand_handle = '0;
  logic [RANK_W-1:0]   rank = '0;
  logic [STAT_W-1:0]   status;
  logic [SLOT_W-1:0]   slot;
  logic                was_inserted, type_known, cand_kept;
  logic [MASK_W-1:0]   type_bits;
  logic [COUNT_W-1:0]  cand_count;
  logic [HANDLE_W-1:0] out_handle;
  logic [SCORE_W-1:0]  out_score;
  logic [LEN_W-1:0]    out_length;
  int fail_count, pending;

  int idle_pct = 0, stall_pct = 0;
  int hold_token = 0, hold_seen = 0, hold_left = 0;
  logic [KEY_W-1:0] key_pool[16];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  linear_probe_key_table uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .key_i(key), .type_mask_i(type_mask),
    .cand_weight_i(cand_weight), .cand_length_i(cand_length),
    .cand_handle_i(cand_handle), .rank_i(rank),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .slot_o(slot), .was_inserted_o(was_inserted),
    .type_known_o(type_known), .type_bits_o(type_bits),
    .cand_count_o(cand_count), .cand_kept_o(cand_kept),
    .out_handle_o(out_handle), .out_score_o(out_score), .out_length_o(out_length)
  );

  lpkt_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .key_i(key), .type_mask_i(type_mask),
    .cand_weight_i(cand_weight), .cand_length_i(cand_length),
    .cand_handle_i(cand_handle), .rank_i(rank),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .slot_i(slot), .was_inserted_i(was_inserted),
    .type_known_i(type_known), .type_bits_i(type_bits),
    .cand_count_i(cand_count), .cand_kept_i(cand_kept),
    .out_handle_i(out_handle), .out_score_i(out_score), .out_length_i(out_length),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 300;
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                      input logic [MASK_W-1:0] m, input logic [SCORE_W-1:0] sc,
                      input logic [LEN_W-1:0] ln, input logic [HANDLE_W-1:0] h,
                      input logic [RANK_W-1:0] rk);
    in_valid <= 1;
    opcode <= op;
    key <= k;
    type_mask <= m;
    cand_weight <= sc;
    cand_length <= ln;
    cand_handle <= h;
    rank <= rk;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_item();
    logic [KEY_W-1:0] k;
    logic [OP_W-1:0] op;
    int r;
    r = $urandom_range(99);
    op = (r < 35) ? OP_ADD : (r < 60) ? OP_MARK : (r < 95) ? OP_READ : OP_READ_ALT;
    k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(15)] : $urandom;
    // one hot key gets enough adds to overflow its candidate list
    if (op == OP_ADD && $urandom_range(99) < 30) k = key_pool[0];
    send(op, k, MASK_W'($urandom),
         SCORE_W'($urandom_range(1) ? $urandom_range(31) : $urandom_range(2)),
         LEN_W'($urandom_range(1) ? $urandom_range(511) : $urandom_range(3)),
         HANDLE_W'($urandom),
         RANK_W'(($urandom_range(99) < 70) ? $urandom_range(21) : $urandom_range(31)));
  endtask

  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    // keys sharing home slot 0xFFE force probe walks that wrap past the end
    for (int i = 0; i < 16; i++)
      key_pool[i] = (i < 6) ? {20'($urandom_range(65535) * 6 + i), 12'hFFE} : $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed corners
    send(OP_READ, 32'h0, 0, 0, 0, 0, 0);                  // missing key
    send(OP_MARK, 32'h0, 4'h0, 0, 0, 0, 0);               // insert with empty mask
    send(OP_MARK, 32'h0, 4'h5, 0, 0, 0, 0);
    send(OP_MARK, 32'h0, 4'hA, 0, 0, 0, 0);
    send(OP_ADD, 32'h0000_1000, 0, 5'd31, 9'd511, 20'hFFFFF, 0);  // collides with key 0
    send(OP_ADD, 32'h0000_1000, 0, 5'd0, 9'd0, 20'h00000, 0);
    send(OP_ADD, 32'h0000_1000, 0, 5'd31, 9'd511, 20'h12345, 0); // equal pair, goes after
    send(OP_ADD, 32'h0000_1000, 0, 5'd31, 9'd0, 20'h54321, 0);   // shorter, goes first
    send(OP_ADD, 32'h0000_1000, 0, 5'd7, 9'd100, 20'hABCDE, 0);
    for (int rk = 0; rk < 6; rk++)
      send(OP_READ, 32'h0000_1000, 0, 0, 0, 0, RANK_W'(rk));
    send(OP_READ, 32'h0000_1000, 0, 0, 0, 0, 5'd31);
    send(OP_READ_ALT, 32'h0000_1000, 0, 0, 0, 0, 1);
    send(OP_MARK, 32'h0000_1000, 4'hF, 0, 0, 0, 0);
    send(OP_ADD, 32'hFFFF_FFFF, 4'hF, 5'd16, 9'd256, 20'h80000, 0); // last slot
    send(OP_ADD, 32'h0000_0FFF, 0, 5'd1, 9'd1, 20'h1, 0);           // wraps past the end, lands in slot 2
    send(OP_READ, 32'h0000_0FFF, 0, 0, 0, 0, 0);
    send(OP_READ, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    drain();

    // random traffic under four idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 29 : 0;
      stall_pct = (ph == 2) ? 70 : (ph == 3) ? 29 : 0;
      for (int n = 0; n < 145; n++) begin
        if (ph == 0 && n == 60) hold_token++;  // long receiver hold-off, sender keeps going
        random_item();
      end
      drain();
    end

    $display("covered %0d results: %0d inserts, %0d not found, %0d table full, %0d dropped adds",
             chk.n_results, chk.n_inserted, chk.n_missing, chk.n_full, chk.n_dropped);
    $display("directed corners plus idle, stall and long hold-off phases all run");
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
